// ----- design/srb_pkg.sv -----
// shared types and constants of the send rate brake
package srb_pkg;

	localparam int BYTE_BITS  = 33;
	localparam int CNT_BITS   = 6;
	localparam int NOW_BITS   = 63;
	localparam int SLEEP_BITS = 63;
	localparam int CFG_BITS   = 40;
	localparam int BURST_BITS = 32;
	localparam int IDX_BITS   = 2;

	localparam logic [IDX_BITS-1:0] REG_MAX_BURST    = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_BURST_PERIOD = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_MIN_SLEEP    = 2'd2;

	localparam logic [BURST_BITS-1:0] MAX_BURST_RST = 32'd64000;
	localparam logic [CFG_BITS-1:0]   PERIOD_RST    = 40'd1000000;
	localparam logic [CFG_BITS-1:0]   MIN_SLEEP_RST = 40'd10000000;

	typedef struct packed {
		logic load;
		logic add_eval;
		logic div_step;
		logic mul_step;
		logic apply;
		logic chk_eval;
		logic chk_fin;
		logic res_load;
	} srb_cmd_t;

	typedef struct packed {
		logic gt;
		logic pending;
		logic out_busy;
	} srb_stat_t;

endpackage

// ----- design/srb_dp.sv -----
// datapath: config registers, pacer state, divider, multiplier, result registers
module srb_dp #(
	parameter int TIME_BITS = 64,
	parameter int UNIT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srb_pkg::IDX_BITS-1:0]  cfg_idx,
	input  logic [srb_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic [UNIT_BITS-1:0]          units,
	input  logic [srb_pkg::NOW_BITS-1:0]  now_ns,
	input  srb_pkg::srb_cmd_t             cmd,
	output srb_pkg::srb_stat_t            stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          do_sleep,
	output logic [srb_pkg::SLEEP_BITS-1:0] sleep_ns
);
	import srb_pkg::*;

	localparam int MW = ((TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS) + 2;

	logic [BURST_BITS-1:0] max_burst_q;
	logic [CFG_BITS-1:0]   period_q;
	logic [CFG_BITS-1:0]   min_sleep_q;

	logic [UNIT_BITS-1:0]  units_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [BYTE_BITS-1:0]  bytes_q;
	logic [TIME_BITS-1:0]  deadline_q;
	logic                  pending_q;
	logic [BYTE_BITS-1:0]  rem_q;
	logic [BYTE_BITS-1:0]  quo_q;
	logic [TIME_BITS-1:0]  acc_q;
	logic                  ovf_q;
	logic [TIME_BITS-1:0]  gap_q;
	logic                  later_q;
	logic                  res_sleep_q;
	logic [SLEEP_BITS-1:0] res_ns_q;
	logic                  out_valid_q;
	logic                  out_sleep_q;
	logic [SLEEP_BITS-1:0] out_ns_q;

	logic [BURST_BITS-1:0] m_eff;
	logic [BYTE_BITS-1:0]  sum;
	logic                  gt;
	logic [BYTE_BITS-1:0]  shl;
	logic                  fits;
	logic [MW-1:0]         mac;
	logic                  mac_ovf;
	logic [TIME_BITS:0]    dl_sum;
	logic                  later;
	logic [TIME_BITS-1:0]  diff;
	logic [63:0]           gap64;
	logic                  long_gap;

	always_comb begin
		m_eff    = (max_burst_q == '0) ? BURST_BITS'(1) : max_burst_q;
		sum      = bytes_q + BYTE_BITS'(units_q);
		gt       = sum > BYTE_BITS'(m_eff);
		shl      = {rem_q[BYTE_BITS-2:0], quo_q[BYTE_BITS-1]};
		fits     = shl >= BYTE_BITS'(m_eff);
		mac      = (MW'(acc_q) << 1) + (quo_q[BYTE_BITS-1] ? MW'(period_q) : MW'(0));
		mac_ovf  = |mac[MW-1:TIME_BITS];
		dl_sum   = {1'b0, deadline_q} + {1'b0, acc_q};
		later    = deadline_q > now_q;
		diff     = deadline_q - now_q;
		gap64    = 64'(gap_q);
		long_gap = MW'(gap_q) > MW'(min_sleep_q);
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_burst_q <= MAX_BURST_RST;
			period_q    <= PERIOD_RST;
			min_sleep_q <= MIN_SLEEP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_BURST:    max_burst_q <= cfg_data[BURST_BITS-1:0];
				REG_BURST_PERIOD: period_q    <= cfg_data;
				REG_MIN_SLEEP:    min_sleep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pacer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q     <= '0;
			deadline_q  <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.add_eval && !gt) begin
				bytes_q <= sum;
			end
			if (cmd.apply) begin
				bytes_q    <= rem_q + BYTE_BITS'(1);
				deadline_q <= (ovf_q || dl_sum[TIME_BITS]) ? '1 : dl_sum[TIME_BITS-1:0];
				pending_q  <= 1'b1;
			end
			if (cmd.chk_fin) begin
				if (!later_q) begin
					deadline_q <= now_q;
				end
				pending_q <= 1'b0;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			units_q     <= units;
			now_q       <= TIME_BITS'(now_ns);
			res_sleep_q <= 1'b0;
			res_ns_q    <= '0;
		end
		if (cmd.add_eval) begin
			rem_q <= '0;
			quo_q <= sum - BYTE_BITS'(1);
			acc_q <= '0;
			ovf_q <= 1'b0;
		end
		// restoring divide, quotient bits shift in from the bottom
		if (cmd.div_step) begin
			rem_q <= fits ? (shl - BYTE_BITS'(m_eff)) : shl;
			quo_q <= {quo_q[BYTE_BITS-2:0], fits};
		end
		// shift-and-add of quotient times period, sticky overflow
		if (cmd.mul_step) begin
			acc_q <= mac[TIME_BITS-1:0];
			ovf_q <= ovf_q || mac_ovf;
			quo_q <= {quo_q[BYTE_BITS-2:0], 1'b0};
		end
		if (cmd.chk_eval) begin
			gap_q   <= diff;
			later_q <= later;
		end
		if (cmd.chk_fin && later_q && long_gap) begin
			res_sleep_q <= 1'b1;
			res_ns_q    <= gap64[63] ? '1 : gap64[62:0];
		end
		if (cmd.res_load) begin
			out_sleep_q <= res_sleep_q;
			out_ns_q    <= res_ns_q;
		end
	end

	assign stat.gt       = gt;
	assign stat.pending  = pending_q;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign do_sleep  = out_sleep_q;
	assign sleep_ns  = out_ns_q;

	a_rem_below_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < BYTE_BITS'(m_eff))
		else $error("divider remainder not below burst size");

	a_apply_marks_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> pending_q)
		else $error("deadline advanced without marking a check");

	a_no_sleep_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !do_sleep) |-> (sleep_ns == '0))
		else $error("sleep length set without sleep");

endmodule

// ----- design/srb_ctrl.sv -----
// controller state machine sequencing add and check items
module srb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               func,
	output logic               in_ready,
	input  srb_pkg::srb_stat_t stat,
	output srb_pkg::srb_cmd_t  cmd
);
	import srb_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADD   = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_APPLY = 3'd4;
	localparam logic [2:0] S_CHK1  = 3'd5;
	localparam logic [2:0] S_CHK2  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(BYTE_BITS - 1);

	logic [2:0]          state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = func ? S_CHK1 : S_ADD;
				end
			end
			S_ADD: begin
				cmd.add_eval = 1'b1;
				cnt_d        = '0;
				state_d      = stat.gt ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = S_MUL;
				end else begin
					cnt_d = cnt_q + CNT_BITS'(1);
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = S_APPLY;
				end else begin
					cnt_d = cnt_q + CNT_BITS'(1);
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_DONE;
			end
			S_CHK1: begin
				cmd.chk_eval = 1'b1;
				state_d      = stat.pending ? S_CHK2 : S_DONE;
			end
			S_CHK2: begin
				cmd.chk_fin = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !stat.out_busy)
		else $error("result loaded over an untaken transfer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_MUL) |-> (cnt_q <= LAST))
		else $error("iteration count out of range");

	a_apply_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> ($past(state_q) == S_MUL))
		else $error("deadline update without multiply");

endmodule

// ----- design/send_rate_brake.sv -----
// top level of the send rate brake leaky-bucket pacer
// An add item (func 0) adds units to the burst counter; a check item (func 1) compares the
// deadline with now_ns and may ask the sender to sleep. Every item yields one result transfer.
// Items are taken one at a time, each after the last has loaded its result. An add item
// that stays within the burst size and any check item skip the divider and multiplier;
// an add item over the burst size runs the 33-step restoring divider that finds the number
// of bursts and the 33-step shift-and-add unit that scales the burst period. A finished result
// waits in an output register, so the next item is taken while it is still unread.
// Registers: 0 max_burst_bytes, 1 burst_period_ns, 2 min_sleep_ns; write only while idle.
module send_rate_brake #(
	parameter int TIME_BITS = 64,
	parameter int UNIT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [srb_pkg::IDX_BITS-1:0]   cfg_idx,
	input  logic [srb_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [UNIT_BITS-1:0]           units,
	input  logic [srb_pkg::NOW_BITS-1:0]   now_ns,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           do_sleep,
	output logic [srb_pkg::SLEEP_BITS-1:0] sleep_ns
);
	import srb_pkg::*;

	srb_cmd_t  cmd;
	srb_stat_t stat;

	srb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srb_dp #(
		.TIME_BITS (TIME_BITS),
		.UNIT_BITS (UNIT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.units     (units),
		.now_ns    (now_ns),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.do_sleep  (do_sleep),
		.sleep_ns  (sleep_ns)
	);

endmodule

// ----- bench/send_rate_brake_tb.sv -----
// self-checking testbench of the send rate brake: directed table, random phases, predictor
`timescale 1ns / 1ps

module send_rate_brake_tb;
	import srb_pkg::*;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;
	localparam logic [IDX_BITS-1:0] REG_NONE = 2'd3;

	localparam logic [SLEEP_BITS-1:0] SLEEP_TOP = '1;
	localparam logic [NOW_BITS-1:0]   NOW_TOP   = '1;
	localparam logic [63:0]           TIME_TOP  = '1;
	localparam logic [63:0]           NOW_SAFE  = 64'h7FFF_0000_0000_0000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	typedef enum {TX_STREAM, TX_BURSTY, TX_SPARSE} tx_mode_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	typedef struct packed {
		logic                  do_sleep;
		logic [SLEEP_BITS-1:0] sleep_ns;
	} pause_t;

	typedef struct packed {
		logic                  late;
		logic                  f;
		logic [15:0]           u;
		logic [NOW_BITS-1:0]   t;
		logic [7:0]            reps;
		logic                  typed;
		logic                  want_sleep;
		logic [SLEEP_BITS-1:0] want_ns;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_BITS-1:0]   cfg_idx = REG_MAX_BURST;
	logic [CFG_BITS-1:0]   cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  func = FUNC_ADD;
	logic [15:0]           units = '0;
	logic [NOW_BITS-1:0]   now_ns = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  do_sleep;
	logic [SLEEP_BITS-1:0] sleep_ns;

	// predictor copy of the pacer state and registers
	logic [32:0]         fill_bytes;
	logic [63:0]         due_ns;
	logic                recheck;
	logic [31:0]         cap_bytes;
	logic [CFG_BITS-1:0] period_ns;
	logic [CFG_BITS-1:0] quiet_ns;

	pause_t   pause_due_q[$];
	int       mismatches = 0;
	int       cycles = 0;
	int       burst_left = 0;
	int       hold_left = 0;
	logic     hold_req = 1'b0;
	logic [15:0] rx_pat = 16'h1;
	tx_mode_t tx_mode = TX_STREAM;
	rx_mode_t rx_mode = RX_OPEN;

	script_row_t script [16] = '{
		'{1'b0, FUNC_CHECK, 16'd0,     63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_CHECK, 16'd0,     NOW_TOP,      8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_ADD,   16'd0,     63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_ADD,   16'hFFFF,  63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_CHECK, 16'd0,     63'd0,        8'd1,  1'b0, 1'b0, 63'd0},
		'{1'b0, FUNC_ADD,   16'hFFFF,  63'd0,        8'd11, 1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_CHECK, 16'd0,     63'd0,        8'd1,  1'b0, 1'b0, 63'd0},
		'{1'b0, FUNC_CHECK, 16'hFFFF,  63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_ADD,   16'h5A5A,  NOW_TOP,      8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_ADD,   16'hA5A5,  63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b0, FUNC_CHECK, 16'd0,     {1'b0, {31{2'b01}}},  8'd1,  1'b0, 1'b0, 63'd0},
		'{1'b0, FUNC_CHECK, 16'd0,     {1'b1, {31{2'b01}}} ^ NOW_TOP,
			8'd1, 1'b1, 1'b0, 63'd0},
		// deadline pushed past the time range, then a long sleep that saturates
		'{1'b1, FUNC_ADD,   16'hFFFF,  63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b1, FUNC_CHECK, 16'd0,     NOW_TOP,      8'd1,  1'b0, 1'b0, 63'd0},
		'{1'b1, FUNC_ADD,   16'hFFFF,  63'd0,        8'd1,  1'b1, 1'b0, 63'd0},
		'{1'b1, FUNC_CHECK, 16'd0,     63'd0,        8'd1,  1'b1, 1'b1, SLEEP_TOP}
	};

	send_rate_brake #(
		.TIME_BITS(64),
		.UNIT_BITS(16)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.units     (units),
		.now_ns    (now_ns),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.do_sleep  (do_sleep),
		.sleep_ns  (sleep_ns)
	);

	always #1 clk = ~clk;

	function automatic logic [NOW_BITS-1:0] rand63();
		return NOW_BITS'({$urandom, $urandom});
	endfunction

	function automatic pause_t pace_predict(input logic f, input logic [15:0] u,
		input logic [NOW_BITS-1:0] t);
		pause_t      res;
		logic [32:0] cap;
		logic [32:0] bursts;
		logic [127:0] step;
		logic [63:0] room;
		logic [63:0] gap;
		res = '0;
		if (f == FUNC_ADD) begin
			cap = (cap_bytes == '0) ? 33'd1 : {1'b0, cap_bytes};
			fill_bytes = fill_bytes + {17'd0, u};
			if (fill_bytes > cap) begin
				bursts = (fill_bytes - 33'd1) / cap;
				fill_bytes = fill_bytes - bursts * cap;
				room = TIME_TOP - due_ns;
				step = 128'(bursts) * 128'(period_ns);
				if (step > 128'(room)) begin
					due_ns = TIME_TOP;
				end else begin
					due_ns = due_ns + step[63:0];
				end
				recheck = 1'b1;
			end
		end else if (recheck) begin
			if (due_ns > {1'b0, t}) begin
				gap = due_ns - {1'b0, t};
				if (gap > 64'(quiet_ns)) begin
					res.do_sleep = 1'b1;
					res.sleep_ns = gap[63] ? SLEEP_TOP : gap[62:0];
				end
			end else begin
				due_ns = {1'b0, t};
			end
			recheck = 1'b0;
		end
		return res;
	endfunction

	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	task automatic next_slot();
		if (burst_left == 0) begin
			case (tx_mode)
				TX_STREAM: burst_left = 64;
				TX_BURSTY: begin
					idle($urandom_range(1, 4));
					burst_left = $urandom_range(1, 8);
				end
				default: begin
					idle($urandom_range(1, 16));
					burst_left = $urandom_range(1, 3);
				end
			endcase
		end
		burst_left--;
	endtask

	task automatic offer(input logic f, input logic [15:0] u, input logic [NOW_BITS-1:0] t,
		input logic typed, input pause_t want);
		pause_t got;
		next_slot();
		@(negedge clk);
		in_valid = 1'b1;
		func = f;
		units = u;
		now_ns = t;
		do @(posedge clk); while (!in_ready);
		got = pace_predict(f, u, t);
		pause_due_q.push_back(typed ? want : got);
	endtask

	task automatic run_script(input logic part);
		script_row_t r;
		for (int i = 0; i < 16; i++) begin
			r = script[i];
			if (r.late == part) begin
				repeat (r.reps) offer(r.f, r.u, r.t, r.typed, {r.want_sleep, r.want_ns});
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pause_due_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MAX_BURST:    cap_bytes = data[BURST_BITS-1:0];
			REG_BURST_PERIOD: period_ns = data;
			REG_MIN_SLEEP:    quiet_ns = data;
			default: ;
		endcase
	endtask

	task automatic set_phase(input logic [CFG_BITS-1:0] cap, input logic [CFG_BITS-1:0] period,
		input logic [CFG_BITS-1:0] quiet, input tx_mode_t tx, input rx_mode_t rx);
		write_reg(REG_MAX_BURST, cap);
		write_reg(REG_BURST_PERIOD, period);
		write_reg(REG_MIN_SLEEP, quiet);
		tx_mode = tx;
		rx_mode = rx;
		rx_pat = 16'($urandom) | 16'h1;
		burst_left = 0;
	endtask

	task automatic pace_items(input int count, input logic flood);
		int          seq_left;
		logic        f;
		logic [15:0] u;
		logic [NOW_BITS-1:0] t;
		logic [63:0] anchor;
		logic [63:0] span;
		logic [63:0] off;
		logic [63:0] pick;
		seq_left = 0;
		repeat (count) begin
			u = 16'($urandom);
			t = rand63();
			if (flood) begin
				f = ($urandom_range(0, 9) == 0) ? FUNC_CHECK : FUNC_ADD;
				if (f == FUNC_ADD) begin
					u = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(60000, 65535));
				end
			end else if ($urandom_range(0, 6) == 0) begin
				f = 1'($urandom);
			end else if (seq_left == 0) begin
				// check with a time near the deadline, on both sides of the sleep bound
				f = FUNC_CHECK;
				anchor = (due_ns > NOW_SAFE) ? NOW_SAFE : due_ns;
				span = 64'(quiet_ns) * 2 + 64'(period_ns) + 64'd4;
				off = {$urandom, $urandom} % span;
				case ($urandom_range(0, 4))
					0: pick = (anchor > 64'(quiet_ns)) ? anchor - 64'(quiet_ns) : '0;
					1: pick = (anchor > 64'(quiet_ns) + 1) ? anchor - 64'(quiet_ns) - 1 : '0;
					2: pick = anchor + off;
					3: pick = (anchor > off) ? anchor - off : '0;
					default: pick = anchor;
				endcase
				t = pick[NOW_BITS-1:0];
				seq_left = $urandom_range(1, 4);
			end else begin
				f = FUNC_ADD;
				case ($urandom_range(0, 3))
					0: u = 16'($urandom_range(0, 255));
					1: u = 16'($urandom_range(65000, 65535));
					default: ;
				endcase
				seq_left--;
			end
			offer(f, u, t, 1'b0, '0);
		end
	endtask

	// receiver back-pressure
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_OPEN:   out_ready = 1'b1;
					RX_COIN:   out_ready = 1'($urandom);
					RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
					default: begin
						rx_pat = {rx_pat[14:0], rx_pat[15]};
						out_ready = rx_pat[0];
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		pause_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pause_due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected transfer: do_sleep %0b sleep_ns %0d", do_sleep, sleep_ns);
				end
			end else begin
				want = pause_due_q.pop_front();
				if (do_sleep !== want.do_sleep || sleep_ns !== want.sleep_ns) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected do_sleep %0b sleep_ns %0d, got %0b %0d",
							want.do_sleep, want.sleep_ns, do_sleep, sleep_ns);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		fill_bytes = '0;
		due_ns = '0;
		recheck = 1'b0;
		cap_bytes = MAX_BURST_RST;
		period_ns = PERIOD_RST;
		quiet_ns = MIN_SLEEP_RST;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		run_script(1'b0);

		for (int p = 0; p < 7; p++) begin
			drain();
			case (p)
				0: begin
					set_phase(40'd1, 40'd1, 40'd0, TX_STREAM, RX_OPEN);
					pace_items(140, 1'b0);
				end
				1: begin
					set_phase(40'hFF_FFFF_FFFF, '1, '1,
						tx_mode_t'($urandom_range(0, 2)), rx_mode_t'($urandom_range(0, 3)));
					pace_items(60, 1'b0);
				end
				2: begin
					write_reg(REG_NONE, {8'($urandom), $urandom});
					set_phase(40'($urandom_range(1000, 200000)), 40'($urandom_range(1, 1 << 24)),
						40'($urandom_range(0, 1 << 26)), TX_STREAM,
						rx_mode_t'($urandom_range(0, 3)));
					hold_req = 1'b1;
					pace_items(150, 1'b0);
				end
				3: begin
					set_phase({8'($urandom), $urandom}, {8'($urandom), $urandom},
						{8'($urandom), $urandom}, tx_mode_t'($urandom_range(0, 2)),
						rx_mode_t'($urandom_range(0, 3)));
					pace_items(120, 1'b0);
				end
				4: begin
					set_phase(40'd100, 40'd0, 40'd5,
						tx_mode_t'($urandom_range(0, 2)), rx_mode_t'($urandom_range(0, 3)));
					pace_items(100, 1'b0);
				end
				5: begin
					set_phase(40'($urandom_range(1, 70000)), 40'($urandom_range(0, 1 << 20)),
						40'd0, tx_mode_t'($urandom_range(0, 2)),
						rx_mode_t'($urandom_range(0, 3)));
					pace_items(150, 1'b0);
				end
				default: begin
					set_phase(40'(MAX_BURST_RST), PERIOD_RST, MIN_SLEEP_RST,
						tx_mode_t'($urandom_range(0, 2)), rx_mode_t'($urandom_range(0, 3)));
					pace_items(100, 1'b0);
				end
			endcase
		end

		run_script(1'b1);

		// zero burst size with the longest period drives the deadline into saturation
		drain();
		set_phase(40'd0, '1, 40'd0,
			tx_mode_t'($urandom_range(0, 2)), rx_mode_t'($urandom_range(0, 3)));
		pace_items(200, 1'b1);

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
